[hw/rtl/ect_pkg.sv]
// shared types, codes and display helpers of the exposure countdown timer
package ect_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_SEC    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HOLDOFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MINUTES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_SEC    = 3'd5;

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_EXPOSE = 2'd2;

  // edit field codes
  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_SEC  = 2'd1;
  localparam logic [1:0] EM_MIN  = 2'd2;

  localparam logic [5:0] SEC_MAX     = 6'd59;
  localparam logic [6:0] MIN_LIMIT   = 7'd99;
  localparam logic [6:0] SEG_BLANK   = 7'h7f;
  localparam logic [6:0] SEG_SEP     = 7'h00;
  localparam logic [4:0] EN_NONE     = 5'h1f;

  localparam logic [6:0] SEG_DIGIT [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  typedef struct packed {
    logic start;
    logic plus;
    logic field;
    logic minus;
  } ect_keys_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } ect_cfg_wr_t;

  // values shown on the display after a tick
  typedef struct packed {
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic [1:0] edit_mode;
    logic [1:0] phase;
  } ect_view_t;

  // divide by ten through a reciprocal multiply, exact for every 7-bit input
  function automatic logic [3:0] ect_div10(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ect_mod10(input logic [6:0] v);
    logic [6:0] q10;
    q10 = {3'd0, ect_div10(v)} * 7'd10;
    return 4'(v - q10);
  endfunction

  function automatic logic [6:0] ect_digit_seg(input logic [3:0] d, input logic blank);
    logic [6:0] s;
    if (blank || d > 4'd9) begin
      s = SEG_BLANK;
    end else begin
      s = SEG_DIGIT[d];
    end
    return s;
  endfunction

endpackage

[hw/rtl/ect_channels.sv]
// valid/ready channel interfaces for key ticks and display results
interface ect_in_if;
  logic valid;
  logic ready;
  logic key_start;
  logic key_plus;
  logic key_field;
  logic key_minus;

  modport source (output valid, key_start, key_plus, key_field, key_minus, input ready);
  modport sink   (input valid, key_start, key_plus, key_field, key_minus, output ready);
endinterface

interface ect_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] digit_enable;
  logic [6:0] segments;
  logic       uv_lamp;
  logic       red_led;
  logic [1:0] phase_now;

  modport source (output valid, digit_enable, segments, uv_lamp, red_led, phase_now,
                  input ready);
  modport sink   (input valid, digit_enable, segments, uv_lamp, red_led, phase_now,
                  output ready);
endinterface

[hw/rtl/ect_keys.sv]
// key arming counters: one trigger per press, re-armed after a holdoff
module ect_keys
  import ect_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  ect_keys_t keys,
  input  logic [7:0] holdoff,
  output ect_keys_t trig
);

  logic [7:0] arm_cnt_r   [4];
  logic [7:0] arm_cnt_nxt [4];
  logic [3:0] pressed;
  logic [3:0] fire;

  assign pressed = {keys.start, keys.plus, keys.field, keys.minus};
  assign trig    = '{start: fire[3], plus: fire[2], field: fire[1], minus: fire[0]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fire[k] = pressed[k] && (arm_cnt_r[k] == 8'd0);
      if (pressed[k]) begin
        arm_cnt_nxt[k] = holdoff;
      end else if (arm_cnt_r[k] != 8'd0) begin
        arm_cnt_nxt[k] = arm_cnt_r[k] - 8'd1;
      end else begin
        arm_cnt_nxt[k] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (!rst_n) begin
        arm_cnt_r[k] <= 8'd0;
      end else if (step) begin
        arm_cnt_r[k] <= arm_cnt_nxt[k];
      end
    end
  end

endmodule

[hw/rtl/ect_ctrl.sv]
// phase control, setting editor, countdown timebase and configuration registers
module ect_ctrl
  import ect_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  ect_keys_t   trig,
  input  ect_cfg_wr_t cfg,
  output logic [7:0]  holdoff,
  output ect_view_t   view
);

  logic [15:0] ticks_r;
  logic [3:0]  settle_sec_r;
  logic [7:0]  holdoff_r;
  logic [6:0]  max_min_r;

  logic [6:0]  min_r, min_nxt, saved_min_r, saved_min_nxt;
  logic [5:0]  sec_r, sec_nxt, saved_sec_r, saved_sec_nxt;
  logic [1:0]  edit_r, edit_nxt, phase_r, phase_nxt;
  logic        pend_r, pend_nxt, elapsed_r, elapsed_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  settle_cnt_r, settle_cnt_nxt;

  logic        idle;
  logic [6:0]  cfg_min, cfg_max;
  logic [5:0]  cfg_sec;

  assign holdoff = holdoff_r;
  assign view    = '{minutes: min_nxt, seconds: sec_nxt, edit_mode: edit_nxt,
                     phase: phase_nxt};
  assign idle    = (phase_r != PH_SETTLE) && (phase_r != PH_EXPOSE);

  // saturated configuration values
  always_comb begin
    cfg_max = cfg.data[6:0];
    if (cfg_max == 7'd0) cfg_max = 7'd1;
    if (cfg_max > MIN_LIMIT) cfg_max = MIN_LIMIT;
    cfg_min = (cfg.data[6:0] > MIN_LIMIT) ? MIN_LIMIT : cfg.data[6:0];
    cfg_sec = (cfg.data[5:0] > SEC_MAX) ? SEC_MAX : cfg.data[5:0];
  end

  always_comb begin
    min_nxt        = min_r;
    sec_nxt        = sec_r;
    saved_min_nxt  = saved_min_r;
    saved_sec_nxt  = saved_sec_r;
    edit_nxt       = edit_r;
    phase_nxt      = phase_r;
    pend_nxt       = pend_r;
    elapsed_nxt    = elapsed_r;
    tick_nxt       = tick_r;
    settle_cnt_nxt = settle_cnt_r;

    if (phase_r == PH_SETTLE) begin
      if (elapsed_r) begin
        elapsed_nxt    = 1'b0;
        settle_cnt_nxt = settle_cnt_r + 4'd1;
        if (settle_cnt_nxt >= settle_sec_r || settle_cnt_nxt == 4'd0) begin
          phase_nxt      = PH_EXPOSE;
          settle_cnt_nxt = 4'd0;
        end
      end
    end else if (phase_r == PH_EXPOSE) begin
      if (trig.start) pend_nxt = 1'b1;
      if (elapsed_r) begin
        elapsed_nxt = 1'b0;
        if ((min_r == 7'd0 && sec_r == 6'd0) || pend_nxt) begin
          min_nxt   = saved_min_r;
          sec_nxt   = saved_sec_r;
          pend_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end else if (sec_r == 6'd0) begin
          sec_nxt = SEC_MAX;
          min_nxt = min_r - 7'd1;
        end else begin
          sec_nxt = sec_r - 6'd1;
        end
      end
    end else begin
      phase_nxt   = PH_IDLE;
      elapsed_nxt = 1'b0;
      if (trig.field) begin
        edit_nxt = (edit_r == EM_NONE) ? EM_SEC : (edit_r == EM_SEC) ? EM_MIN : EM_NONE;
      end
      if (trig.start) pend_nxt = ~pend_r;
      if (edit_nxt == EM_SEC) begin
        if (trig.plus) sec_nxt = (sec_r >= SEC_MAX) ? SEC_MAX : sec_r + 6'd1;
        if (trig.minus && sec_nxt != 6'd0) sec_nxt = sec_nxt - 6'd1;
      end else if (edit_nxt == EM_MIN) begin
        if (trig.plus) min_nxt = (min_r >= max_min_r) ? max_min_r : min_r + 7'd1;
        if (trig.minus && min_nxt != 7'd0) min_nxt = min_nxt - 7'd1;
      end
      // start with no field open: save the setting as preset and run
      if (pend_nxt && edit_nxt == EM_NONE) begin
        saved_min_nxt  = min_nxt;
        saved_sec_nxt  = sec_nxt;
        pend_nxt       = 1'b0;
        tick_nxt       = 16'd0;
        elapsed_nxt    = 1'b0;
        settle_cnt_nxt = 4'd0;
        phase_nxt      = (settle_sec_r == 4'd0) ? PH_EXPOSE : PH_SETTLE;
      end
    end

    // timebase
    if (phase_nxt == PH_SETTLE || phase_nxt == PH_EXPOSE) begin
      tick_nxt = tick_nxt + 16'd1;
      if (tick_nxt >= ticks_r) begin
        tick_nxt    = 16'd0;
        elapsed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r      <= 16'd500;
      settle_sec_r <= 4'd6;
      holdoff_r    <= 8'd255;
      max_min_r    <= 7'd30;
      min_r        <= 7'd0;
      sec_r        <= 6'd0;
      saved_min_r  <= 7'd0;
      saved_sec_r  <= 6'd0;
      edit_r       <= EM_NONE;
      phase_r      <= PH_IDLE;
      pend_r       <= 1'b0;
      elapsed_r    <= 1'b0;
      tick_r       <= 16'd0;
      settle_cnt_r <= 4'd0;
    end else if (step) begin
      min_r        <= min_nxt;
      sec_r        <= sec_nxt;
      saved_min_r  <= saved_min_nxt;
      saved_sec_r  <= saved_sec_nxt;
      edit_r       <= edit_nxt;
      phase_r      <= phase_nxt;
      pend_r       <= pend_nxt;
      elapsed_r    <= elapsed_nxt;
      tick_r       <= tick_nxt;
      settle_cnt_r <= settle_cnt_nxt;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_TICKS_PER_SEC: ticks_r <= (cfg.data == 16'd0) ? 16'd1 : cfg.data;
        CFG_SETTLE_SEC:    settle_sec_r <= cfg.data[3:0];
        CFG_KEY_HOLDOFF:   holdoff_r <= (cfg.data[7:0] == 8'd0) ? 8'd1 : cfg.data[7:0];
        CFG_MAX_MINUTES:   max_min_r <= cfg_max;
        CFG_PRESET_MIN: begin
          saved_min_r <= cfg_min;
          if (idle) min_r <= cfg_min;
        end
        CFG_PRESET_SEC: begin
          saved_sec_r <= cfg_sec;
          if (idle) sec_r <= cfg_sec;
        end
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/ect_disp.sv]
// display multiplexer: position counter and segment decode with blanking
module ect_disp
  import ect_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  ect_view_t  view,
  output logic [4:0] digit_enable,
  output logic [6:0] segments
);

  localparam logic [2:0] POS_MIN_TENS = 3'd1;
  localparam logic [2:0] POS_MIN_ONES = 3'd2;
  localparam logic [2:0] POS_SEP      = 3'd3;
  localparam logic [2:0] POS_SEC_TENS = 3'd4;
  localparam logic [2:0] POS_SEC_ONES = 3'd5;

  logic [2:0] pos_r, pos_nxt, pos;
  logic [3:0] min_tens, min_ones, sec_tens, sec_ones;
  logic       blank_min, blank_sec;

  assign min_tens  = ect_div10(view.minutes);
  assign min_ones  = ect_mod10(view.minutes);
  assign sec_tens  = ect_div10({1'b0, view.seconds});
  assign sec_ones  = ect_mod10({1'b0, view.seconds});
  assign blank_min = (view.edit_mode == EM_SEC);
  assign blank_sec = (view.edit_mode == EM_MIN);

  always_comb begin
    pos = (pos_r < POS_MIN_TENS || pos_r > POS_SEC_ONES) ? POS_MIN_TENS : pos_r;
    pos_nxt = (pos >= POS_SEC_ONES) ? POS_MIN_TENS : pos + 3'd1;
    unique case (pos)
      POS_MIN_TENS: begin
        digit_enable = 5'h1e;
        segments     = ect_digit_seg(min_tens, min_tens == 4'd0 || blank_min);
      end
      POS_MIN_ONES: begin
        digit_enable = 5'h1d;
        segments     = ect_digit_seg(min_ones, blank_min);
      end
      POS_SEP: begin
        digit_enable = EN_NONE;
        segments     = SEG_SEP;
      end
      POS_SEC_TENS: begin
        digit_enable = 5'h1b;
        segments     = ect_digit_seg(sec_tens, blank_sec);
      end
      default: begin
        digit_enable = 5'h17;
        segments     = ect_digit_seg(sec_ones, blank_sec);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_MIN_TENS;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[hw/rtl/exposure_countdown_timer.sv]
// top level of the exposure countdown timer with multiplexed display
// Each input transfer is one display tick carrying the four key levels; each tick
// gives exactly one result transfer with the active-low position enables and
// segments, the lamp and ready outputs and the phase. Ticks go into an input
// register, the tick's state update and digit decode run combinationally between that
// register and the result register, so a new tick is taken every cycle while the
// result side keeps up; a tick's result is registered when its tick is processed.
// While a result waits on a stalled output the input register still takes one more
// tick; after that the input stalls until the waiting result transfers.
// Configuration writes take effect at once unless a tick is processed in the same
// cycle, which drops them, and belong to quiet periods with no tick in flight.
module exposure_countdown_timer
  import ect_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ect_in_if.sink                in_ch,
  ect_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // input register
  logic      in_valid_r;
  ect_keys_t keys_r;

  // result register
  logic       out_valid_r;
  logic [4:0] enable_r;
  logic [6:0] seg_r;
  logic [1:0] phase_out_r;

  logic        advance;   // result register can take a new value
  logic        step;      // registered tick is processed this cycle
  ect_keys_t   trig;
  ect_cfg_wr_t cfg;
  ect_view_t   view;
  logic [7:0]  holdoff;
  logic [4:0]  enable_c;
  logic [6:0]  seg_c;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;
  assign cfg         = '{we: cfg_we, index: cfg_index, data: cfg_wdata};

  ect_keys u_keys (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .keys    (keys_r),
    .holdoff (holdoff),
    .trig    (trig)
  );

  ect_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .trig    (trig),
    .cfg     (cfg),
    .holdoff (holdoff),
    .view    (view)
  );

  ect_disp u_disp (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .view         (view),
    .digit_enable (enable_c),
    .segments     (seg_c)
  );

  // control of both register stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      keys_r <= '{start: in_ch.key_start, plus: in_ch.key_plus,
                  field: in_ch.key_field, minus: in_ch.key_minus};
    end
    if (step) begin
      enable_r    <= enable_c;
      seg_r       <= seg_c;
      phase_out_r <= view.phase;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digit_enable = enable_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.phase_now    = phase_out_r;
  assign out_ch.uv_lamp      = (phase_out_r == PH_EXPOSE);
  assign out_ch.red_led      = (phase_out_r == PH_IDLE);

endmodule

[test/exposure_countdown_timer_tb.sv]
// self-checking testbench for the exposure countdown timer: directed and random key ticks
module exposure_countdown_timer_tb;
  import ect_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

  // key codes in ect_keys_t bit order: start, plus, field, minus
  localparam logic [3:0] KEY_NONE  = 4'b0000;
  localparam logic [3:0] KEY_START = 4'b1000;
  localparam logic [3:0] KEY_PLUS  = 4'b0100;
  localparam logic [3:0] KEY_FIELD = 4'b0010;
  localparam logic [3:0] KEY_MINUS = 4'b0001;
  localparam logic [3:0] KEY_ALL   = 4'b1111;

  // index of each key in the shadow arming counters
  localparam int IX_START = 0;
  localparam int IX_PLUS  = 1;
  localparam int IX_FIELD = 2;
  localparam int IX_MINUS = 3;

  // display positions in scan order
  localparam logic [2:0] POS_MIN_TENS = 3'd1;
  localparam logic [2:0] POS_MIN_ONES = 3'd2;
  localparam logic [2:0] POS_COLON    = 3'd3;
  localparam logic [2:0] POS_SEC_TENS = 3'd4;
  localparam logic [2:0] POS_SEC_ONES = 3'd5;

  // active-low digit patterns g..a
  localparam logic [6:0] GLYPH [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  // one display result
  typedef struct packed {
    logic [4:0] enables;
    logic [6:0] segs;
    logic       lamp;
    logic       ready_led;
    logic [1:0] ph;
  } disp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ect_in_if  in_bus ();
  ect_out_if out_bus ();

  exposure_countdown_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the timer registers, reset values
  logic [15:0] tm_tps        = 16'd500;
  logic [3:0]  tm_settle_sec = 4'd6;
  logic [7:0]  tm_holdoff    = 8'd255;
  logic [6:0]  tm_max_min    = 7'd30;

  // shadow copy of the timer state, reset values
  logic [6:0] tm_min       = 7'd0;
  logic [5:0] tm_sec       = 6'd0;
  logic [6:0] tm_saved_min = 7'd0;
  logic [5:0] tm_saved_sec = 6'd0;
  logic [1:0] tm_edit      = EM_NONE;
  logic [1:0] tm_phase     = PH_IDLE;
  logic       tm_pending   = 1'b0;
  logic [7:0] tm_arm [4]   = '{8'd0, 8'd0, 8'd0, 8'd0};
  logic [15:0] tm_tick     = 16'd0;
  logic [3:0] tm_settle_cnt = 4'd0;
  logic [2:0] tm_mux       = POS_MIN_TENS;
  logic       tm_sec_flag  = 1'b0;

  // display results owed by the block, oldest first
  disp_t expected_disp [$];
  disp_t seen_disp;
  disp_t due_disp;

  int fail_count;
  int cycle_count;
  int rx_hold_left;
  int rx_stall_left;
  bit tx_gaps_on;
  bit rx_stalls_on;

  // clock, period 2
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // in-range value most of the time, otherwise any 16-bit value to hit saturation
  function automatic logic [15:0] reg_value(input int lo, input int hi);
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic logic [6:0] glyph(input logic [6:0] d, input bit blank);
    if (blank || d > 7'd9) return SEG_BLANK;
    return GLYPH[d[3:0]];
  endfunction

  // key pattern for one tick: mostly clean single presses and releases, some noise
  function automatic ect_keys_t random_keys();
    int r;
    int which;
    r = $urandom_range(0, 99);
    if (r < 8) return ect_keys_t'(4'($urandom_range(0, 15)));
    if (r < 55) return ect_keys_t'(KEY_NONE);
    which = $urandom_range(0, 3);
    // keep aborts rare so that runs reach zero
    if (tm_phase == PH_EXPOSE && which == 0 && $urandom_range(0, 15) != 0) begin
      return ect_keys_t'(KEY_NONE);
    end
    return ect_keys_t'(KEY_START >> which);
  endfunction

  // advances the shadow timer by one tick and gives the display result it shows
  function automatic disp_t timer_tick(input ect_keys_t k);
    logic [3:0] held;
    logic [3:0] fire;
    disp_t      r;
    int         i;
    held = {k.minus, k.field, k.plus, k.start};

    // key arming: trigger on a press only when the holdoff has run out
    for (i = 0; i < 4; i++) begin
      fire[i] = held[i] && (tm_arm[i] == 8'd0);
      if (held[i]) begin
        tm_arm[i] = tm_holdoff;
      end else if (tm_arm[i] != 8'd0) begin
        tm_arm[i] = tm_arm[i] - 8'd1;
      end
    end

    case (tm_phase)
      PH_SETTLE: begin
        // keys ignored, count settle seconds
        if (tm_sec_flag) begin
          tm_sec_flag = 1'b0;
          tm_settle_cnt = tm_settle_cnt + 4'd1;
          if (tm_settle_cnt >= tm_settle_sec || tm_settle_cnt == 4'd0) begin
            tm_phase = PH_EXPOSE;
            tm_settle_cnt = 4'd0;
          end
        end
      end
      PH_EXPOSE: begin
        // start requests an abort, served on the next second boundary
        if (fire[IX_START]) tm_pending = 1'b1;
        if (tm_sec_flag) begin
          tm_sec_flag = 1'b0;
          if ((tm_min == 7'd0 && tm_sec == 6'd0) || tm_pending) begin
            tm_min = tm_saved_min;
            tm_sec = tm_saved_sec;
            tm_pending = 1'b0;
            tm_phase = PH_IDLE;
          end else if (tm_sec == 6'd0) begin
            tm_sec = SEC_MAX;
            tm_min = tm_min - 7'd1;
          end else begin
            tm_sec = tm_sec - 6'd1;
          end
        end
      end
      default: begin
        tm_phase = PH_IDLE;
        tm_sec_flag = 1'b0;
        if (fire[IX_FIELD]) begin
          case (tm_edit)
            EM_NONE: tm_edit = EM_SEC;
            EM_SEC:  tm_edit = EM_MIN;
            default: tm_edit = EM_NONE;
          endcase
        end
        if (fire[IX_START]) tm_pending = ~tm_pending;
        if (tm_edit == EM_SEC) begin
          if (fire[IX_PLUS]) tm_sec = (tm_sec >= SEC_MAX) ? SEC_MAX : tm_sec + 6'd1;
          if (fire[IX_MINUS] && tm_sec != 6'd0) tm_sec = tm_sec - 6'd1;
        end else if (tm_edit == EM_MIN) begin
          // above the clamp plus snaps down to it
          if (fire[IX_PLUS]) tm_min = (tm_min >= tm_max_min) ? tm_max_min : tm_min + 7'd1;
          if (fire[IX_MINUS] && tm_min != 7'd0) tm_min = tm_min - 7'd1;
        end
        // a pending start only fires once no field is being edited
        if (tm_pending && tm_edit == EM_NONE) begin
          tm_saved_min = tm_min;
          tm_saved_sec = tm_sec;
          tm_pending = 1'b0;
          tm_tick = 16'd0;
          tm_sec_flag = 1'b0;
          tm_settle_cnt = 4'd0;
          tm_phase = (tm_settle_sec == 4'd0) ? PH_EXPOSE : PH_SETTLE;
        end
      end
    endcase

    // timebase runs only while a run is active
    if (tm_phase == PH_SETTLE || tm_phase == PH_EXPOSE) begin
      tm_tick = tm_tick + 16'd1;
      if (tm_tick >= tm_tps) begin
        tm_tick = 16'd0;
        tm_sec_flag = 1'b1;
      end
    end

    // display scan with leading-zero and edit-field blanking
    if (tm_mux < POS_MIN_TENS || tm_mux > POS_SEC_ONES) tm_mux = POS_MIN_TENS;
    case (tm_mux)
      POS_MIN_TENS: begin
        r.enables = 5'h1e;
        r.segs = glyph(tm_min / 7'd10, (tm_min / 7'd10 == 7'd0) || tm_edit == EM_SEC);
      end
      POS_MIN_ONES: begin
        r.enables = 5'h1d;
        r.segs = glyph(tm_min % 7'd10, tm_edit == EM_SEC);
      end
      POS_COLON: begin
        r.enables = EN_NONE;
        r.segs = SEG_SEP;
      end
      POS_SEC_TENS: begin
        r.enables = 5'h1b;
        r.segs = glyph({1'b0, tm_sec} / 7'd10, tm_edit == EM_MIN);
      end
      default: begin
        r.enables = 5'h17;
        r.segs = glyph({1'b0, tm_sec} % 7'd10, tm_edit == EM_MIN);
      end
    endcase
    tm_mux = (tm_mux >= POS_SEC_ONES) ? POS_MIN_TENS : tm_mux + 3'd1;

    r.lamp = (tm_phase == PH_EXPOSE);
    r.ready_led = (tm_phase == PH_IDLE);
    r.ph = tm_phase;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // one tick transfer, with an optional gap before it; predicts on acceptance
  task automatic send_tick(input ect_keys_t k);
    int gap;
    gap = tx_gaps_on ? gap_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      // key levels wander while nothing is offered
      in_bus.valid     <= 1'b0;
      in_bus.key_start <= 1'($urandom_range(0, 1));
      in_bus.key_plus  <= 1'($urandom_range(0, 1));
      in_bus.key_field <= 1'($urandom_range(0, 1));
      in_bus.key_minus <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.key_start <= k.start;
    in_bus.key_plus  <= k.plus;
    in_bus.key_field <= k.field;
    in_bus.key_minus <= k.minus;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    expected_disp.push_back(timer_tick(k));
  endtask

  // stop offering ticks and wait for every owed result plus the pipeline latency
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_disp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write on the block and in the shadow copy, with the same saturation
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    bit idle;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    idle = (tm_phase != PH_SETTLE && tm_phase != PH_EXPOSE);
    case (idx)
      CFG_TICKS_PER_SEC: tm_tps = (v == 16'd0) ? 16'd1 : v;
      CFG_SETTLE_SEC:    tm_settle_sec = v[3:0];
      CFG_KEY_HOLDOFF:   tm_holdoff = (v[7:0] == 8'd0) ? 8'd1 : v[7:0];
      CFG_MAX_MINUTES: begin
        if (v[6:0] == 7'd0) tm_max_min = 7'd1;
        else if (v[6:0] > MIN_LIMIT) tm_max_min = MIN_LIMIT;
        else tm_max_min = v[6:0];
      end
      CFG_PRESET_MIN: begin
        tm_saved_min = (v[6:0] > MIN_LIMIT) ? MIN_LIMIT : v[6:0];
        if (idle) tm_min = tm_saved_min;
      end
      CFG_PRESET_SEC: begin
        tm_saved_sec = (v[5:0] > SEC_MAX) ? SEC_MAX : v[5:0];
        if (idle) tm_sec = tm_saved_sec;
      end
      default: ;
    endcase
  endtask

  // reset values on the display, all five positions plus one wrap
  task automatic test_reset_display();
    repeat (6) send_tick(KEY_NONE);
  endtask

  // zero and over-range writes saturate where the block clamps them, unknown indexes are ignored
  task automatic test_register_limits();
    wait_drained();
    write_reg(CFG_TICKS_PER_SEC, 16'd0);
    write_reg(CFG_SETTLE_SEC, 16'd0);
    write_reg(CFG_KEY_HOLDOFF, 16'd0);
    write_reg(CFG_MAX_MINUTES, 16'hffff);
    write_reg(CFG_PRESET_MIN, 16'hffff);
    write_reg(CFG_PRESET_SEC, 16'hffff);
    write_reg(CFG_UNUSED_A, 16'($urandom_range(0, 65535)));
    write_reg(CFG_UNUSED_B, 16'($urandom_range(0, 65535)));
    repeat (3) send_tick(KEY_NONE);
    wait_drained();
    // clamp now sits below the minutes setting
    write_reg(CFG_MAX_MINUTES, 16'd0);
  endtask

  // field cycling, seconds clamp, minutes above clamp, floor at zero, held key
  task automatic test_edit_fields();
    send_tick(KEY_FIELD);
    send_tick(KEY_PLUS);
    send_tick(KEY_MINUS);
    send_tick(KEY_FIELD);
    send_tick(KEY_PLUS);
    send_tick(KEY_MINUS);
    send_tick(KEY_NONE);
    send_tick(KEY_MINUS);
    send_tick(KEY_PLUS);
    send_tick(KEY_PLUS);
    send_tick(KEY_MINUS);
    send_tick(KEY_FIELD);
  endtask

  // start while editing waits, a second press cancels, abort during expose
  task automatic test_start_while_editing();
    send_tick(KEY_FIELD);
    send_tick(KEY_START);
    send_tick(KEY_NONE);
    send_tick(KEY_START);
    send_tick(KEY_FIELD);
    send_tick(KEY_START);
    send_tick(KEY_FIELD);
    send_tick(KEY_NONE);
    send_tick(KEY_START);
    send_tick(KEY_NONE);
  endtask

  // start with the minutes field open only pends; then with zero settle all keys at once close the field and cancel it
  task automatic test_countdown();
    wait_drained();
    write_reg(CFG_PRESET_MIN, 16'd0);
    write_reg(CFG_PRESET_SEC, 16'd1);
    write_reg(CFG_SETTLE_SEC, 16'd2);
    send_tick(KEY_START);
    repeat (5) send_tick(KEY_NONE);
    wait_drained();
    write_reg(CFG_SETTLE_SEC, 16'd0);
    send_tick(KEY_ALL);
    send_tick(KEY_FIELD);
    send_tick(KEY_NONE);
    send_tick(KEY_FIELD);
    repeat (2) send_tick(KEY_NONE);
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_output_stall();
    wait_drained();
    write_reg(CFG_TICKS_PER_SEC, 16'd2);
    write_reg(CFG_KEY_HOLDOFF, 16'd2);
    tx_gaps_on = 1'b0;
    rx_hold_left = 64;
    repeat (40) send_tick(random_keys());
    tx_gaps_on = 1'b1;
  endtask

  // random sessions under several register settings, extremes among them
  task automatic test_random_sessions();
    int p;
    for (p = 0; p < 8; p++) begin
      wait_drained();
      case (p)
        1: begin
          // longest settle at the fastest timebase
          write_reg(CFG_TICKS_PER_SEC, 16'd1);
          write_reg(CFG_SETTLE_SEC, 16'd15);
          write_reg(CFG_KEY_HOLDOFF, 16'd1);
          write_reg(CFG_MAX_MINUTES, 16'd2);
          write_reg(CFG_PRESET_MIN, 16'd0);
          write_reg(CFG_PRESET_SEC, 16'd3);
        end
        5: begin
          // upper extremes of every register
          write_reg(CFG_TICKS_PER_SEC, 16'd65535);
          write_reg(CFG_SETTLE_SEC, 16'd15);
          write_reg(CFG_KEY_HOLDOFF, 16'd255);
          write_reg(CFG_MAX_MINUTES, 16'd99);
          write_reg(CFG_PRESET_MIN, 16'd99);
          write_reg(CFG_PRESET_SEC, 16'd59);
        end
        default: begin
          write_reg(CFG_TICKS_PER_SEC, 16'($urandom_range(0, 4)));
          write_reg(CFG_SETTLE_SEC, reg_value(0, 3));
          write_reg(CFG_KEY_HOLDOFF, reg_value(1, 4));
          write_reg(CFG_MAX_MINUTES, reg_value(1, 99));
          write_reg(CFG_PRESET_MIN, reg_value(0, 1));
          write_reg(CFG_PRESET_SEC, reg_value(0, 12));
          if (p == 2) write_reg(CFG_UNUSED_B, 16'($urandom_range(0, 65535)));
        end
      endcase
      // one session runs with no idling on either side
      tx_gaps_on = (p != 3);
      rx_stalls_on = (p != 3);
      repeat ((p == 5) ? 40 : 95) send_tick(random_keys());
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // result side: random stalls, plus the long hold-off counted down here
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_bus.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_stall_left > 0) begin
      out_bus.ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
      out_bus.ready <= 1'b0;
      rx_stall_left <= gap_length();
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // every result transfer is checked field by field against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      seen_disp = '{enables: out_bus.digit_enable, segs: out_bus.segments,
                    lamp: out_bus.uv_lamp, ready_led: out_bus.red_led,
                    ph: out_bus.phase_now};
      if (expected_disp.size() == 0) begin
        note_failure($sformatf("result transfer with no tick owed, got %h", seen_disp));
      end else begin
        due_disp = expected_disp.pop_front();
        if (seen_disp.enables !== due_disp.enables)
          note_failure($sformatf("digit_enable expected %h got %h",
                                 due_disp.enables, seen_disp.enables));
        if (seen_disp.segs !== due_disp.segs)
          note_failure($sformatf("segments expected %h got %h",
                                 due_disp.segs, seen_disp.segs));
        if (seen_disp.lamp !== due_disp.lamp)
          note_failure($sformatf("uv_lamp expected %b got %b",
                                 due_disp.lamp, seen_disp.lamp));
        if (seen_disp.ready_led !== due_disp.ready_led)
          note_failure($sformatf("red_led expected %b got %b",
                                 due_disp.ready_led, seen_disp.ready_led));
        if (seen_disp.ph !== due_disp.ph)
          note_failure($sformatf("phase_now expected %0d got %0d",
                                 due_disp.ph, seen_disp.ph));
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // every block input known from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.key_start = 1'b0;
    in_bus.key_plus  = 1'b0;
    in_bus.key_field = 1'b0;
    in_bus.key_minus = 1'b0;
    out_bus.ready    = 1'b0;
    tx_gaps_on       = 1'b1;
    rx_stalls_on     = 1'b1;
    rx_hold_left     = 0;
    rx_stall_left    = 0;
    fail_count       = 0;
    cycle_count      = 0;

    // synchronous reset held from time zero, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_display();
    test_register_limits();
    test_edit_fields();
    test_start_while_editing();
    test_countdown();
    test_output_stall();
    test_random_sessions();

    wait_drained();
    if (fail_count == 0 && expected_disp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ect_pkg.sv
hw/rtl/ect_channels.sv
hw/rtl/ect_keys.sv
hw/rtl/ect_ctrl.sv
hw/rtl/ect_disp.sv
hw/rtl/exposure_countdown_timer.sv
test/exposure_countdown_timer_tb.sv
